/* src/dryden_gust_filter_step_macros.svh */
// assertion macros for the dryden gust filter step block
// used by the top level only, expects aclk and aresetn in scope
`ifndef DRYDEN_GUST_FILTER_STEP_MACROS_SVH
`define DRYDEN_GUST_FILTER_STEP_MACROS_SVH

// same-cycle implication
`define DGF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DGF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dgf_pkg.sv */
// shared types and constants for the dryden gust filter step block
// no dependencies
package dgf_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;
    // width of the scaled coefficients k1..k6 (all below 2^84 in magnitude)
    localparam int KW       = 86;
    localparam int NUM_COEF = 5;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 48;

    typedef enum logic [CFG_AW-1:0] {
        REG_ALPHA  = 3'd0,
        REG_BETA   = 3'd1,
        REG_DELTA  = 3'd2,
        REG_GAMMA  = 3'd3,
        REG_ENABLE = 3'd4
    } cfg_idx_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       accept;
        logic       prep1;
        logic       prep2;
        logic       prep3;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic       mac_mul;
        logic       mac_add;
        logic       fin;
        logic       zero;
        logic [2:0] idx;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic enable;
        logic out_free;
    } status_t;

endpackage

/* src/dgf_ctrl.sv */
// sequencing state machine for the dryden gust filter step block
// depends on dgf_pkg
module dgf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  dgf_pkg::status_t status,
    output dgf_pkg::cmd_t   cmd
);
    import dgf_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PREP1  = 9'b000000010,
        ST_PREP2  = 9'b000000100,
        ST_PREP3  = 9'b000001000,
        ST_DLOAD  = 9'b000010000,
        ST_DITER  = 9'b000100000,
        ST_DSTORE = 9'b001000000,
        ST_MAC    = 9'b010000000,
        ST_FIN    = 9'b100000000
    } state_t;

    localparam logic [4:0] MAC_LAST  = 5'd5;
    localparam logic [2:0] COEF_LAST = 3'(NUM_COEF - 1);

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] ci_reg, ci_next;
    logic       zero_reg, zero_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ci_next    = ci_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        cmd.zero   = zero_reg;
        cmd.idx    = ci_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    zero_next  = !status.enable;
                    state_next = status.enable ? ST_PREP1 : ST_FIN;
                end
            end
            ST_PREP1: begin
                cmd.prep1  = 1'b1;
                state_next = ST_PREP2;
            end
            ST_PREP2: begin
                cmd.prep2  = 1'b1;
                state_next = ST_PREP3;
            end
            ST_PREP3: begin
                cmd.prep3  = 1'b1;
                ci_next    = '0;
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DITER;
            end
            ST_DITER: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (&cnt_reg) begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                cmd.div_store = 1'b1;
                if (ci_reg == COEF_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end else begin
                    ci_next    = ci_reg + 3'd1;
                    state_next = ST_DLOAD;
                end
            end
            ST_MAC: begin
                cmd.idx     = cnt_reg[2:0];
                cmd.mac_mul = (cnt_reg != MAC_LAST);
                cmd.mac_add = (cnt_reg != '0);
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == MAC_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ci_reg    <= '0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ci_reg    <= ci_next;
            zero_reg  <= zero_next;
        end
    end

endmodule

/* src/dgf_datapath.sv */
// datapath of the dryden gust filter step: config, coefficient prep,
// shared restoring divider, shared multiply-accumulate, history, output beat
// depends on dgf_pkg
module dgf_datapath #(
    parameter int COEF_FRAC_BITS = dgf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dgf_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [dgf_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic [15:0]                 in_dt,
    input  logic [15:0]                 in_noise,
    input  dgf_pkg::cmd_t               cmd,
    output dgf_pkg::status_t            status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 out_gust,
    output logic                        out_sat
);
    import dgf_pkg::*;

    localparam int NW = KW + COEF_FRAC_BITS;
    localparam int AW = 68;

    // coefficient slots and multiply-accumulate terms share one index
    localparam logic [2:0] T_A1 = 3'd0;
    localparam logic [2:0] T_A2 = 3'd1;
    localparam logic [2:0] T_B0 = 3'd2;
    localparam logic [2:0] T_B1 = 3'd3;
    localparam logic [2:0] T_B2 = 3'd4;

    logic [31:0] alpha_reg;
    logic [47:0] beta_reg, delta_reg, gamma_reg;
    logic        enable_reg;

    logic [15:0] t_reg;
    logic signed [15:0] u0_reg;
    logic signed [15:0] n1_reg, n2_reg;
    logic signed [31:0] g1_reg, g2_reg;

    logic [31:0] tt_reg;
    logic [63:0] dtv_reg, btv_reg, atv_reg;
    logic [KW-1:0] k1_reg;
    logic [KW-1:0] knum_reg [NUM_COEF];

    logic [KW-1:0] rem_reg;
    logic [31:0]   low_reg, q_reg;
    logic          ovf_reg, neg_reg;
    logic [31:0]   coef_reg [NUM_COEF];

    logic signed [64:0]   prod_reg;
    logic signed [AW-1:0] acc_reg;

    logic        out_valid_reg;
    logic [31:0] gust_reg;
    logic        sat_reg;

    // config writes, coefficient writes clear the history
    logic cfg_clear;
    assign cfg_clear = cfg_we && (cfg_addr == REG_ALPHA || cfg_addr == REG_BETA
                       || cfg_addr == REG_DELTA || cfg_addr == REG_GAMMA);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= '0;
            beta_reg   <= '0;
            delta_reg  <= '0;
            gamma_reg  <= '0;
            enable_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ALPHA:  alpha_reg  <= cfg_wdata[31:0];
                REG_BETA:   beta_reg   <= cfg_wdata;
                REG_DELTA:  delta_reg  <= cfg_wdata;
                REG_GAMMA:  gamma_reg  <= cfg_wdata;
                REG_ENABLE: enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // scaled coefficients k1..k6 (all multiplied by dt^2 * 2^48)
    logic [KW-1:0] tt_w, dtv_w, btv_w, atv_w, gam_w;
    logic [KW-1:0] k1_next, k2_next, k3_next, k4_next, k5_next, k6_next;
    always_comb begin
        tt_w    = KW'(tt_reg);
        dtv_w   = KW'(dtv_reg);
        btv_w   = KW'(btv_reg);
        atv_w   = KW'(atv_reg);
        gam_w   = KW'(gamma_reg);
        k1_next = (tt_w << 16) + (dtv_w << 17) + (gam_w << 34);
        k2_next = (tt_w << 17) - (gam_w << 35);
        k3_next = (tt_w << 16) - (dtv_w << 17) + (gam_w << 34);
        k4_next = atv_w + (btv_w << 17);
        k5_next = atv_w << 1;
        k6_next = atv_w - (btv_w << 17);
    end

    // divider setup: magnitude, overflow check on the upper part
    logic [KW-1:0] num_sel, mag;
    logic          num_neg;
    logic [NW-1:0] nfull, nhi;
    always_comb begin
        num_sel = knum_reg[cmd.idx];
        num_neg = num_sel[KW-1];
        mag     = num_neg ? (~num_sel + KW'(1)) : num_sel;
        nfull   = NW'(mag) << COEF_FRAC_BITS;
        nhi     = nfull >> 32;
    end

    // one restoring step
    logic [KW:0] trial, trial_diff;
    logic        trial_ge;
    always_comb begin
        trial      = {rem_reg, low_reg[31]};
        trial_diff = trial - {1'b0, k1_reg};
        trial_ge   = (trial >= {1'b0, k1_reg});
    end

    // clip quotient and apply sign
    logic [31:0] lim, qmag, coef_next;
    always_comb begin
        lim       = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qmag      = (ovf_reg || q_reg > lim) ? lim : q_reg;
        coef_next = neg_reg ? (~qmag + 32'd1) : qmag;
    end

    // multiplier operand for each term
    logic [32:0] op;
    logic signed [64:0] prod_next;
    always_comb begin
        case (cmd.idx)
            T_A1:    op = ~{g1_reg[31], g1_reg} + 33'd1;
            T_A2:    op = ~{g2_reg[31], g2_reg} + 33'd1;
            T_B0:    op = {{16{u0_reg[15]}}, u0_reg, 1'b0};
            T_B1:    op = {{16{n1_reg[15]}}, n1_reg, 1'b0};
            T_B2:    op = {{16{n2_reg[15]}}, n2_reg, 1'b0};
            default: op = '0;
        endcase
        prod_next = $signed(coef_reg[cmd.idx]) * $signed(op);
    end

    // final shift and saturation
    logic signed [AW-1:0] sh;
    logic        sat_hi, sat_lo;
    logic [31:0] y;
    always_comb begin
        sh     = acc_reg >>> COEF_FRAC_BITS;
        sat_hi = !sh[AW-1] && (sh[AW-2:31] != '0);
        sat_lo = sh[AW-1] && (sh[AW-2:31] != '1);
        if (sat_hi) begin
            y = 32'h7FFF_FFFF;
        end else if (sat_lo) begin
            y = 32'h8000_0000;
        end else begin
            y = sh[31:0];
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            t_reg  <= (in_dt == '0) ? 16'd1 : in_dt;
            u0_reg <= in_noise;
        end
        if (cmd.prep1) begin
            tt_reg  <= 32'(t_reg) * 32'(t_reg);
            dtv_reg <= 64'(delta_reg) * 64'(t_reg);
            btv_reg <= 64'(beta_reg) * 64'(t_reg);
        end
        if (cmd.prep2) begin
            atv_reg <= 64'(alpha_reg) * 64'(tt_reg);
        end
        if (cmd.prep3) begin
            k1_reg         <= k1_next;
            knum_reg[T_A1] <= k2_next;
            knum_reg[T_A2] <= k3_next;
            knum_reg[T_B0] <= k4_next;
            knum_reg[T_B1] <= k5_next;
            knum_reg[T_B2] <= k6_next;
        end
        if (cmd.div_load) begin
            neg_reg <= num_neg;
            ovf_reg <= (nhi >= NW'(k1_reg));
            rem_reg <= (nhi >= NW'(k1_reg)) ? '0 : nhi[KW-1:0];
            low_reg <= nfull[31:0];
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[KW-1:0] : trial[KW-1:0];
            q_reg   <= {q_reg[30:0], trial_ge};
            low_reg <= {low_reg[30:0], 1'b0};
        end
        if (cmd.div_store) begin
            coef_reg[cmd.idx] <= coef_next;
        end
        if (cmd.prep1) begin
            acc_reg <= '0;
        end else if (cmd.mac_add) begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (cmd.mac_mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.fin) begin
            gust_reg <= cmd.zero ? '0 : y;
            sat_reg  <= cmd.zero ? 1'b0 : (sat_hi || sat_lo);
        end
    end

    // filter history
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            n1_reg <= '0;
            n2_reg <= '0;
            g1_reg <= '0;
            g2_reg <= '0;
        end else if (cmd.fin && !cmd.zero) begin
            n2_reg <= n1_reg;
            n1_reg <= u0_reg;
            g2_reg <= g1_reg;
            g1_reg <= y;
        end
    end

    // output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.enable   = enable_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_gust        = gust_reg;
    assign out_sat         = sat_reg;

endmodule

/* src/dryden_gust_filter_step.sv */
// Dryden gust filter, one axis: second-order bilinear IIR with per-beat step.
// Input beat: s_tdata = {noise_sample Q1.15, step_dt Q0.16}. Output beat:
// m_tdata = gust Q16.16 (saturated), m_tuser = saturated flag.
// Coefficients are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, which the block itself leaves unenforced.
// Writing alpha, beta, delta or gamma clears the filter history.
// One beat is worked on at a time. s_tready is high only when idle.
// Enabled, a beat passes through the prep steps, 5 normalized coefficients from
// one shared 1-bit-per-cycle restoring divider, the shared multiply-accumulate
// and the finish state, and the block is back in idle before it takes another beat.
// Disabled, an accepted beat goes straight to the finish state and gives a zero
// result, history untouched.
// The result sits in an output register; when that register is still full and
// m_tready is low, the block holds its finished result in its finish state
// and takes no new beat.
// Reset (aresetn low, synchronous) clears the sequencer state, the config
// registers including enable, and history, and drops m_tvalid.
// depends on dgf_pkg, dgf_ctrl, dgf_datapath, dryden_gust_filter_step_macros.svh
`include "dryden_gust_filter_step_macros.svh"

module dryden_gust_filter_step #(
    parameter int COEF_FRAC_BITS = dgf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [dgf_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [dgf_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [15:0] step_dt, [31:16] noise_sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] gust
    output logic                        m_tuser    // [0] saturated
);
    import dgf_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    dgf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    dgf_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_dt     (s_tdata[15:0]),
        .in_noise  (s_tdata[31:16]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gust  (m_tdata),
        .out_sat   (m_tuser)
    );

    // checks
    `DGF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "beat accepted while busy")
    `DGF_ASSERT_NOW(a_sat_extreme, m_tvalid && m_tuser, m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000, "saturated flag with in-range gust")
    `DGF_ASSERT_NEXT(a_result_from_work, !m_tvalid && !s_tready, !s_tready || m_tvalid, "returned to idle without a result")

endmodule

/* test/testbench.sv */
// self-checking testbench for the dryden gust filter step block
// a directed table, then randomized beats, results checked against a filter predictor or table values
// depends on dgf_pkg and dryden_gust_filter_step
module testbench;
    import dgf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC       = COEF_FRAC_BITS_DEF;
    localparam int          CYCLE_MAX  = 2000000;
    localparam logic [2:0]  REG_UNUSED = 3'd7;
    localparam logic signed [127:0] GUST_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] GUST_MIN = -128'sh8000_0000;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [47:0] val;
        logic [15:0] dt;
        logic [15:0] nz;
        logic        typed;
        logic [31:0] gust;
        logic        sat;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] gust;
        logic        sat;
    } gust_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [47:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // filter state as the predictor sees it
    logic [31:0]        mdl_alpha;
    logic [47:0]        mdl_beta, mdl_delta, mdl_gamma;
    logic               mdl_en;
    logic signed [15:0] mdl_u1, mdl_u2;
    logic signed [31:0] mdl_y1, mdl_y2;

    gust_beat_t gust_q[$];
    int         err_cnt = 0;
    int         cycle_cnt = 0;
    int         src_idle_pct = 0;
    int         snk_stall_pct = 0;

    dryden_gust_filter_step DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        gust_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (gust_q.size() == 0) begin
                $error("unexpected result beat gust=%h", m_tdata);
                err_cnt++;
            end else begin
                want = gust_q.pop_front();
                if (m_tdata !== want.gust) begin
                    $error("gust expected %h actual %h", want.gust, m_tdata);
                    err_cnt++;
                end
                if (m_tuser !== want.sat) begin
                    $error("saturated expected %b actual %b", want.sat, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // num/den with FRAC fraction bits, toward zero, clipped to 32 bits signed
    function automatic logic signed [63:0] coef_ratio(input logic signed [127:0] num,
                                                       input logic signed [127:0] den);
        logic               neg;
        logic signed [127:0] mag, quo, lim;
        neg = num[127];
        mag = neg ? -num : num;
        lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
        quo = (mag <<< FRAC) / den;
        if (quo > lim) quo = lim;
        return neg ? -quo[63:0] : quo[63:0];
    endfunction

    // one filter step, updates the history when enabled
    function automatic gust_beat_t gust_predict(input logic [15:0] dt_in,
                                                input logic signed [15:0] nz);
        gust_beat_t          res;
        logic signed [127:0] t, tt, dtv, btv, atv, gam, k1, k2, k3, k4, k5, k6, acc;
        logic signed [63:0]  a1, a2, b0, b1, b2;
        logic signed [31:0]  y;
        res = '0;
        if (!mdl_en) return res;
        t   = (dt_in == 16'd0) ? 128'sd1 : {112'd0, dt_in};
        tt  = t * t;
        dtv = t * {80'd0, mdl_delta};
        btv = t * {80'd0, mdl_beta};
        atv = tt * {96'd0, mdl_alpha};
        gam = {80'd0, mdl_gamma};
        k1 = (tt <<< 16) + (dtv <<< 17) + (gam <<< 34);
        k2 = (tt <<< 17) - (gam <<< 35);
        k3 = (tt <<< 16) - (dtv <<< 17) + (gam <<< 34);
        k4 = atv + (btv <<< 17);
        k5 = atv <<< 1;
        k6 = atv - (btv <<< 17);
        a1 = coef_ratio(k2, k1);
        a2 = coef_ratio(k3, k1);
        b0 = coef_ratio(k4, k1);
        b1 = coef_ratio(k5, k1);
        b2 = coef_ratio(k6, k1);
        // noise is Q1.15, so it takes a factor two to line up with Q16.16
        acc = 128'sd2 * b0 * nz + 128'sd2 * b1 * mdl_u1 + 128'sd2 * b2 * mdl_u2
              - a1 * mdl_y1 - a2 * mdl_y2;
        acc = acc >>> FRAC;
        if (acc > GUST_MAX) begin
            y = 32'sh7FFF_FFFF;
            res.sat = 1'b1;
        end else if (acc < GUST_MIN) begin
            y = 32'sh8000_0000;
            res.sat = 1'b1;
        end else begin
            y = acc[31:0];
        end
        res.gust = y;
        mdl_u2 = mdl_u1;
        mdl_u1 = nz;
        mdl_y2 = mdl_y1;
        mdl_y1 = y;
        return res;
    endfunction

    task automatic wait_drained();
        while (gust_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // register write while idle, mirrored into the predictor
    task automatic reg_write(input logic [2:0] idx, input logic [47:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ALPHA:  mdl_alpha = val[31:0];
            REG_BETA:   mdl_beta  = val;
            REG_DELTA:  mdl_delta = val;
            REG_GAMMA:  mdl_gamma = val;
            REG_ENABLE: mdl_en    = val[0];
            default: ;
        endcase
        if (idx <= REG_GAMMA) begin
            mdl_u1 = '0; mdl_u2 = '0; mdl_y1 = '0; mdl_y2 = '0;
        end
    endtask

    // push one input beat, called and returning at a falling edge
    task automatic send_beat(input logic [15:0] dt, input logic [15:0] nz,
                             input logic typed, input gust_beat_t typed_res);
        gust_beat_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {nz, dt};
        do @(posedge aclk); while (!s_tready);
        res = gust_predict(dt, nz);
        gust_q.push_back(typed ? typed_res : res);
        @(negedge aclk);
    endtask

    // random coefficient set, magnitudes spread over the whole field
    task automatic random_setting();
        logic [47:0] v;
        v = {16'($urandom_range(65535)), $urandom()};
        reg_write(REG_ALPHA, (v >> ($urandom_range(47, 16))) & 48'hFFFF_FFFF);
        v = {16'($urandom_range(65535)), $urandom()};
        reg_write(REG_BETA, ($urandom_range(9) == 0) ? 48'hFFFF_FFFF_FFFF
                            : v >> $urandom_range(47, 10));
        v = {16'($urandom_range(65535)), $urandom()};
        reg_write(REG_DELTA, ($urandom_range(9) == 0) ? 48'd0 : v >> $urandom_range(47, 10));
        v = {16'($urandom_range(65535)), $urandom()};
        reg_write(REG_GAMMA, ($urandom_range(9) == 0) ? 48'hFFFF_FFFF_FFFF
                             : v >> $urandom_range(47, 14));
        reg_write(REG_ENABLE, ($urandom_range(9) < 8) ? 48'd1 : 48'd0);
    endtask

    stim_row_t dir_tab [0:28] = '{
        // disabled after reset: always zero
        '{ROW_BEAT, 3'd0, 48'd0, 16'd100, 16'h7FFF, 1'b1, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd0, 16'h8000, 1'b1, 32'd0, 1'b0},
        // plausible coefficients
        '{ROW_CFG, REG_ALPHA, 48'h1_0000, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_BETA, 48'h1_0000, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_DELTA, 48'h2_0000, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_GAMMA, 48'h1_0000, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_ENABLE, 48'd1, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd655, 16'h7FFF, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd655, 16'h8000, 1'b0, 32'd0, 1'b0},
        // zero step counts as one
        '{ROW_BEAT, 3'd0, 48'd0, 16'd0, 16'd12345, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd1, 16'h7FFF, 1'b0, 32'd0, 1'b0},
        // disable keeps history
        '{ROW_CFG, REG_ENABLE, 48'd0, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd500, 16'd1000, 1'b1, 32'd0, 1'b0},
        '{ROW_CFG, REG_ENABLE, 48'd1, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd500, 16'hFC18, 1'b0, 32'd0, 1'b0},
        // unknown index is ignored
        '{ROW_CFG, REG_UNUSED, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd1000, 16'd0, 1'b0, 32'd0, 1'b0},
        // coefficient write clears history
        '{ROW_CFG, REG_GAMMA, 48'd0, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd1, 16'h7FFF, 1'b0, 32'd0, 1'b0},
        // huge gain, no damping: gust clips
        '{ROW_CFG, REG_ALPHA, 48'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_BETA, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_DELTA, 48'd0, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'hFFFF, 16'h7FFF, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'hFFFF, 16'h8000, 1'b0, 32'd0, 1'b0},
        // everything at the top
        '{ROW_CFG, REG_DELTA, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_CFG, REG_GAMMA, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'd1, 16'h8000, 1'b0, 32'd0, 1'b0},
        '{ROW_BEAT, 3'd0, 48'd0, 16'hFFFF, 16'h7FFF, 1'b0, 32'd0, 1'b0}
    };

    initial begin
        gust_beat_t typed_res;
        mdl_alpha = '0; mdl_beta = '0; mdl_delta = '0; mdl_gamma = '0; mdl_en = 1'b0;
        mdl_u1 = '0; mdl_u2 = '0; mdl_y1 = '0; mdl_y2 = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                s_tvalid <= 1'b0;
                reg_write(dir_tab[i].addr, dir_tab[i].val);
            end else begin
                typed_res.gust = dir_tab[i].gust;
                typed_res.sat  = dir_tab[i].sat;
                send_beat(dir_tab[i].dt, dir_tab[i].nz, dir_tab[i].typed, typed_res);
            end
        end

        // random part over four idling phases
        typed_res = '0;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 62) : 0;
            snk_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 62) : 0;
            for (int s = 0; s < 5; s++) begin
                s_tvalid <= 1'b0;
                random_setting();
                repeat ($urandom_range(50, 80)) begin
                    send_beat(($urandom_range(7) == 0) ? 16'hFFFF
                                                       : 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 1'b0, typed_res);
                    // hold off until the block has emptied
                    if ($urandom_range(49) == 0) begin
                        s_tvalid <= 1'b0;
                        wait_drained();
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (400) @(negedge aclk);
        if (gust_q.size() != 0) begin
            $error("%0d gust results never arrived", gust_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* dryden_gust_filter_step.f */
+incdir+src
src/dgf_pkg.sv
src/dgf_ctrl.sv
src/dgf_datapath.sv
src/dryden_gust_filter_step.sv
test/testbench.sv
